// ===== rtl/core/skms_pkg.sv =====
// shared constants, codes and types of the stable key merge sorter
package skms_pkg;

   // default capacity in keys
   localparam int unsigned MaxItemsDef = 4096;

   // field widths
   localparam int unsigned KEY_W = 7;
   localparam int unsigned POS_W = 12;

   // stream data widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned REQ_PAD_W  = REQ_DATA_W - KEY_W - POS_W;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - POS_W - KEY_W;

   // request kinds carried on tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // status of the merge sequencer towards the top level
   typedef struct packed {
      logic busy;   // sequencer owns the memories
      logic done;   // one-cycle pulse when the set is sorted
      logic sel;    // index buffer that holds the sorted order
   } merge_stat_type;

endpackage

// ===== rtl/core/skms_ram.sv =====
// synchronous memory with one write port and two registered read ports
module skms_ram #(
   parameter  int unsigned WIDTH = 12,
   parameter  int unsigned DEPTH = 4096,
   localparam int unsigned AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr0,
   input  logic [AW-1:0]    raddr1,
   output logic [WIDTH-1:0] rdata0,
   output logic [WIDTH-1:0] rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read ports, registered
   always_ff @(posedge clock) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
   end

endmodule

// ===== rtl/core/skms_merge.sv =====
// bottom-up merge sequencer: builds the identity order, then ping-pongs merge passes
module skms_merge
   import skms_pkg::*;
#(
   parameter  int unsigned MAX_ITEMS = MaxItemsDef,
   localparam int unsigned IW        = $clog2(MAX_ITEMS),
   localparam int unsigned CW        = $clog2(MAX_ITEMS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CW-1:0]     n,
   output merge_stat_type    stat,
   output logic [IW-1:0]     src_raddr0,
   output logic [IW-1:0]     src_raddr1,
   input  logic [IW-1:0]     src_rdata0,
   input  logic [IW-1:0]     src_rdata1,
   output logic [IW-1:0]     key_raddr0,
   output logic [IW-1:0]     key_raddr1,
   input  logic [KEY_W-1:0]  key_rdata0,
   input  logic [KEY_W-1:0]  key_rdata1,
   output logic              dst_we,
   output logic [IW-1:0]     dst_waddr,
   output logic [IW-1:0]     dst_wdata
);

   // positions need headroom for lo + 2 * width
   localparam int unsigned SW = CW + 2;

   localparam logic [2:0] MS_IDLE = 3'd0;
   localparam logic [2:0] MS_INIT = 3'd1;
   localparam logic [2:0] MS_RD   = 3'd2;
   localparam logic [2:0] MS_KEY  = 3'd3;
   localparam logic [2:0] MS_CMP  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic [SW-1:0] width_ff, width_in;
   logic [SW-1:0] lo_ff, lo_in;
   logic [SW-1:0] mid_ff, mid_in;
   logic [SW-1:0] hi_ff, hi_in;
   logic [SW-1:0] a_ff, a_in;
   logic [SW-1:0] b_ff, b_in;
   logic [SW-1:0] w_ff, w_in;
   logic          sel_ff, sel_in;
   logic          done_ff, done_in;

   logic [SW-1:0] n_x;
   logic [SW-1:0] w_next;
   logic [SW-1:0] next_lo;
   logic          pass_end;
   logic [SW-1:0] seg_lo;
   logic [SW-1:0] seg_wd;
   logic [SW-1:0] seg_sum1;
   logic [SW-1:0] seg_sum2;
   logic [SW-1:0] seg_mid;
   logic [SW-1:0] seg_hi;
   logic          take_a;

   assign n_x    = SW'(n_ff);
   assign w_next = w_ff + SW'(1);

   // head reads of both runs, then keys of the two heads
   assign src_raddr0 = a_ff[IW-1:0];
   assign src_raddr1 = b_ff[IW-1:0];
   assign key_raddr0 = src_rdata0;
   assign key_raddr1 = src_rdata1;

   // stable choice: left run wins on equal keys
   assign take_a = (a_ff < mid_ff) && ((b_ff >= hi_ff) || (key_rdata0 <= key_rdata1));

   // destination write: identity during init, chosen head during merge
   assign dst_we    = (state_ff == MS_INIT) || (state_ff == MS_CMP);
   assign dst_waddr = w_ff[IW-1:0];
   assign dst_wdata = (state_ff == MS_INIT) ? w_ff[IW-1:0]
                    : (take_a ? src_rdata0 : src_rdata1);

   // next segment bounds
   always_comb begin
      next_lo  = lo_ff + (width_ff << 1);
      pass_end = next_lo >= n_x;
      if (state_ff == MS_INIT) begin
         seg_lo = '0;
         seg_wd = SW'(1);
      end else if (pass_end) begin
         seg_lo = '0;
         seg_wd = width_ff << 1;
      end else begin
         seg_lo = next_lo;
         seg_wd = width_ff;
      end
      seg_sum1 = seg_lo + seg_wd;
      seg_sum2 = seg_lo + (seg_wd << 1);
      seg_mid  = (seg_sum1 < n_x) ? seg_sum1 : n_x;
      seg_hi   = (seg_sum2 < n_x) ? seg_sum2 : n_x;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      width_in = width_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      w_in     = w_ff;
      sel_in   = sel_ff;
      done_in  = 1'b0;
      case (state_ff)
         MS_IDLE: begin
            if (start) begin
               n_in     = n;
               w_in     = '0;
               sel_in   = 1'b1;
               state_in = MS_INIT;
            end
         end
         MS_INIT: begin
            w_in = w_next;
            if (w_next == n_x) begin
               sel_in   = 1'b0;
               width_in = seg_wd;
               if (n_x <= SW'(1)) begin
                  done_in  = 1'b1;
                  state_in = MS_IDLE;
               end else begin
                  lo_in    = seg_lo;
                  mid_in   = seg_mid;
                  hi_in    = seg_hi;
                  a_in     = seg_lo;
                  b_in     = seg_mid;
                  w_in     = seg_lo;
                  state_in = MS_RD;
               end
            end
         end
         MS_RD: begin
            state_in = MS_KEY;
         end
         MS_KEY: begin
            state_in = MS_CMP;
         end
         MS_CMP: begin
            w_in     = w_next;
            state_in = MS_RD;
            if (take_a) begin
               a_in = a_ff + SW'(1);
            end else begin
               b_in = b_ff + SW'(1);
            end
            // segment finished
            if (w_next == hi_ff) begin
               if (pass_end) begin
                  sel_in = ~sel_ff;
               end
               if (pass_end && (seg_wd >= n_x)) begin
                  done_in  = 1'b1;
                  state_in = MS_IDLE;
               end else begin
                  width_in = seg_wd;
                  lo_in    = seg_lo;
                  mid_in   = seg_mid;
                  hi_in    = seg_hi;
                  a_in     = seg_lo;
                  b_in     = seg_mid;
                  w_in     = seg_lo;
               end
            end
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         sel_ff   <= sel_in;
      end
   end

   // position registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      w_ff     <= w_in;
   end

   assign stat.busy = state_ff != MS_IDLE;
   assign stat.done = done_ff;
   assign stat.sel  = sel_ff;

endmodule

// ===== rtl/core/stable_key_merge_sorter.sv =====
// top level of the stable key merge sorter: request handling, memories and read path
//
// Load requests (tuser 0) store one 7-bit key each, one per cycle while req_tready is
// high, tagged with the next arrival index; a load with tlast ends the set and starts
// a stable ascending merge sort of the arrival indices by key, equal keys keeping arrival
// order. The sort writes the identity order and then runs merge passes, each output
// chosen by the loop of the merge unit (read run heads, read their keys, compare and
// write) over one memory port pair; no request is taken meanwhile. Read requests
// (tuser 1) take a sorted position and return the arrival index and key there, with
// valid_res low and zero fields when no set is sorted or the position is not below
// the count. A load after a sorted set starts a new set, and keys beyond MAX_ITEMS
// are dropped. Stores come up unwritten after reset and need no clearing.
module stable_key_merge_sorter
   import skms_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key_value[6:0], position[18:7], zero pad
   input  logic                  req_tuser,   // op
   input  logic                  req_tlast,   // last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // original_index[11:0], key_out[18:12], zero pad
   output logic                  rsp_tuser    // valid_res
);

   localparam int unsigned IW  = $clog2(MAX_ITEMS);
   localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
   localparam int unsigned PXW = CW + POS_W;
   localparam int unsigned XW  = IW + POS_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SORT   = 2'd1;
   localparam logic [1:0] ST_RD_IDX = 2'd2;
   localparam logic [1:0] ST_RD_KEY = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             sorted_ff, sorted_in;
   logic             rd_ok_ff, rd_ok_in;
   logic [IW-1:0]    rd_idx_ff, rd_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic             rsp_flag_ff, rsp_flag_in;

   logic [KEY_W-1:0] req_key;
   logic [POS_W-1:0] req_pos;
   logic             req_fire;
   logic             load_fire;
   logic             read_fire;
   logic [CW-1:0]    count_base;
   logic             has_room;
   logic [CW-1:0]    new_count;
   logic [PXW-1:0]   pos_x;
   logic [PXW-1:0]   count_x;
   logic             in_range;
   logic             out_free;
   logic [XW-1:0]    idx_x;

   merge_stat_type   stat;
   logic [IW-1:0]    m_src_raddr0, m_src_raddr1;
   logic [IW-1:0]    m_src_rdata0, m_src_rdata1;
   logic [IW-1:0]    m_key_raddr0, m_key_raddr1;
   logic             m_dst_we;
   logic [IW-1:0]    m_dst_waddr, m_dst_wdata;

   logic             key_we;
   logic [IW-1:0]    key_waddr;
   logic [IW-1:0]    key_raddr0;
   logic [KEY_W-1:0] key_rdata0, key_rdata1;
   logic [IW-1:0]    buf_raddr0;
   logic             buf0_we, buf1_we;
   logic [IW-1:0]    buf0_rdata0, buf0_rdata1;
   logic [IW-1:0]    buf1_rdata0, buf1_rdata1;
   logic [IW-1:0]    res_rdata0;

   // request decode
   assign req_key    = req_tdata[KEY_W-1:0];
   assign req_pos    = req_tdata[KEY_W+POS_W-1:KEY_W];
   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == OP_LOAD);
   assign read_fire  = req_fire && (req_tuser == OP_READ);

   // load bookkeeping: a load after a sorted set restarts at index zero
   assign count_base = sorted_ff ? '0 : count_ff;
   assign has_room   = count_base < CW'(MAX_ITEMS);
   assign new_count  = has_room ? count_base + CW'(1) : count_base;
   assign key_we     = load_fire && has_room;
   assign key_waddr  = count_base[IW-1:0];

   // read range check
   assign pos_x    = PXW'(req_pos);
   assign count_x  = PXW'(count_ff);
   assign in_range = sorted_ff && (pos_x < count_x);

   // memory port sharing: the sequencer owns the memories while sorting,
   // the read path uses port 0 otherwise; reads and writes never meet on one buffer
   assign buf_raddr0   = stat.busy ? m_src_raddr0 : pos_x[IW-1:0];
   assign res_rdata0   = stat.sel ? buf1_rdata0 : buf0_rdata0;
   assign m_src_rdata0 = res_rdata0;
   assign m_src_rdata1 = stat.sel ? buf1_rdata1 : buf0_rdata1;
   assign buf0_we      = m_dst_we && stat.sel;
   assign buf1_we      = m_dst_we && !stat.sel;
   assign key_raddr0   = stat.busy ? m_key_raddr0
                       : ((state_ff == ST_RD_IDX) ? res_rdata0 : rd_idx_ff);

   skms_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_key_ram (
      .clock  (clock),
      .we     (key_we),
      .waddr  (key_waddr),
      .wdata  (req_key),
      .raddr0 (key_raddr0),
      .raddr1 (m_key_raddr1),
      .rdata0 (key_rdata0),
      .rdata1 (key_rdata1)
   );

   skms_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_buf0_ram (
      .clock  (clock),
      .we     (buf0_we),
      .waddr  (m_dst_waddr),
      .wdata  (m_dst_wdata),
      .raddr0 (buf_raddr0),
      .raddr1 (m_src_raddr1),
      .rdata0 (buf0_rdata0),
      .rdata1 (buf0_rdata1)
   );

   skms_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_buf1_ram (
      .clock  (clock),
      .we     (buf1_we),
      .waddr  (m_dst_waddr),
      .wdata  (m_dst_wdata),
      .raddr0 (buf_raddr0),
      .raddr1 (m_src_raddr1),
      .rdata0 (buf1_rdata0),
      .rdata1 (buf1_rdata1)
   );

   skms_merge #(.MAX_ITEMS(MAX_ITEMS)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .start      (load_fire && req_tlast),
      .n          (new_count),
      .stat       (stat),
      .src_raddr0 (m_src_raddr0),
      .src_raddr1 (m_src_raddr1),
      .src_rdata0 (m_src_rdata0),
      .src_rdata1 (m_src_rdata1),
      .key_raddr0 (m_key_raddr0),
      .key_raddr1 (m_key_raddr1),
      .key_rdata0 (key_rdata0),
      .key_rdata1 (key_rdata1),
      .dst_we     (m_dst_we),
      .dst_waddr  (m_dst_waddr),
      .dst_wdata  (m_dst_wdata)
   );

   // arrival index widened to the result field
   assign idx_x    = XW'(rd_idx_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // request sequencing and result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sorted_in    = sorted_ff;
      rd_ok_in     = rd_ok_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_flag_in  = rsp_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load_fire) begin
               count_in  = new_count;
               sorted_in = 1'b0;
               if (req_tlast) begin
                  state_in = ST_SORT;
               end
            end else if (read_fire) begin
               rd_ok_in = in_range;
               state_in = ST_RD_IDX;
            end
         end
         ST_SORT: begin
            if (stat.done) begin
               sorted_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_RD_IDX: begin
            rd_idx_in = res_rdata0;
            state_in  = ST_RD_KEY;
         end
         ST_RD_KEY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = rd_ok_ff;
               rsp_idx_in   = rd_ok_ff ? idx_x[POS_W-1:0] : '0;
               rsp_key_in   = rd_ok_ff ? key_rdata0 : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sorted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ok_ff    <= rd_ok_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_key_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_flag_ff;

   // no request is taken while the sequencer owns the memories
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !req_tready)
      else $error("request accepted during sort");

   // completion only arrives while waiting for it
   a_done_in_sort: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == ST_SORT))
      else $error("sort completion outside sort state");

   // an invalid result carries zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("invalid result with non-zero fields");

   // the set never grows past capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("item count beyond capacity");

endmodule
